// ===== design/bresenham_line_pixel_generator_top_macros.svh =====
// Assertion macros for the line pixel generator.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BLPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BLPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blpg_pkg.sv =====
// Shared types and constants for the line pixel generator.
package blpg_pkg;

  localparam int COORD_BITS = 8;
  localparam int COLOR_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    action_t                 action;
    logic [COORD_BITS-1:0]   x_start;
    logic [COORD_BITS-1:0]   y_start;
    logic [COORD_BITS-1:0]   x_end;
    logic [COORD_BITS-1:0]   y_end;
    logic [COLOR_BITS-1:0]   line_color;
  } in_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0]   pixel_color;
    logic                    last;
  } out_req_t;

endpackage

// ===== design/bresenham_line_pixel_generator_top.sv =====
// Bresenham line rasterizer: start and step requests in, pixel requests out.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_req  (action, endpoints, color)
//  out_    | output    | out_valid/out_stall | out_req (x, y, color, last)
//
// Each accepted request is handled in the cycle it is accepted; its pixel (none for a
// step while idle) appears in the output register in the next cycle, so one pixel per
// cycle while out_stall is low; the line state update (one compare, three adds) sets that rate.
// Reset (synchronous, rst_n low) leaves the block idle with no pixel pending.
// in_stall follows out_stall only while a pixel sits unaccepted in the
// output register; a taken pixel frees it for a new request in the same cycle.
`include "bresenham_line_pixel_generator_top_macros.svh"

module bresenham_line_pixel_generator_top
  import blpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  localparam int N = COORD_BITS;
  localparam int E = ERR_BITS;

  // line state
  logic                  active_r, active_nxt;
  logic                  major_x_r, major_x_nxt;
  logic [N-1:0]          cur_x_r, cur_x_nxt;
  logic [N-1:0]          cur_y_r, cur_y_nxt;
  logic [N-1:0]          major_end_r, major_end_nxt;
  logic                  minor_down_r, minor_down_nxt;
  logic [E-1:0]          err_r, err_nxt;
  logic [E-1:0]          diag_r, diag_nxt;
  logic [E-1:0]          straight_r, straight_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  out_req_t              out_req_r, out_req_nxt;

  logic                  in_accept;
  logic                  out_taken;

  // start decode
  logic [N-1:0]          dx, dy, sx, sy, ex, ey, dmaj, dmin;
  logic                  st_major_x, st_swap;
  logic [E-1:0]          dmin2;

  // step decode
  logic                  minor_step;
  logic [N-1:0]          maj, mnr, maj_inc, mnr_mov;

  assign out_taken = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // endpoint analysis for a start request
  always_comb begin
    dx = (in_req.x_end >= in_req.x_start) ? (in_req.x_end - in_req.x_start)
                                          : (in_req.x_start - in_req.x_end);
    dy = (in_req.y_end >= in_req.y_start) ? (in_req.y_end - in_req.y_start)
                                          : (in_req.y_start - in_req.y_end);
    st_major_x = (dx >= dy);
    st_swap    = st_major_x ? (in_req.x_start > in_req.x_end)
                            : (in_req.y_start > in_req.y_end);
    sx = st_swap ? in_req.x_end   : in_req.x_start;
    sy = st_swap ? in_req.y_end   : in_req.y_start;
    ex = st_swap ? in_req.x_start : in_req.x_end;
    ey = st_swap ? in_req.y_start : in_req.y_end;
    dmaj  = st_major_x ? dx : dy;
    dmin  = st_major_x ? dy : dx;
    dmin2 = {2'b00, dmin, 1'b0};
  end

  // next pixel of the running line
  always_comb begin
    minor_step = !err_r[E-1];
    maj        = major_x_r ? cur_x_r : cur_y_r;
    mnr        = major_x_r ? cur_y_r : cur_x_r;
    maj_inc    = maj + {{(N-1){1'b0}}, 1'b1};
    if (!minor_step) begin
      mnr_mov = mnr;
    end else if (minor_down_r) begin
      mnr_mov = mnr - {{(N-1){1'b0}}, 1'b1};
    end else begin
      mnr_mov = mnr + {{(N-1){1'b0}}, 1'b1};
    end
  end

  // state and output update
  always_comb begin
    active_nxt     = active_r;
    major_x_nxt    = major_x_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    major_end_nxt  = major_end_r;
    minor_down_nxt = minor_down_r;
    err_nxt        = err_r;
    diag_nxt       = diag_r;
    straight_nxt   = straight_r;
    color_nxt      = color_r;
    out_valid_nxt  = out_valid_r && !out_taken;
    out_req_nxt    = out_req_r;

    if (in_accept) begin
      case (in_req.action)
        ACT_START: begin
          major_x_nxt    = st_major_x;
          major_end_nxt  = st_major_x ? ex : ey;
          minor_down_nxt = st_major_x ? !(ey > sy) : !(ex > sx);
          err_nxt        = dmin2 - {3'b000, dmaj};
          diag_nxt       = dmin2 - {2'b00, dmaj, 1'b0};
          straight_nxt   = dmin2;
          color_nxt      = in_req.line_color;
          cur_x_nxt      = sx;
          cur_y_nxt      = sy;
          active_nxt     = ((st_major_x ? sx : sy) != (st_major_x ? ex : ey));
          out_valid_nxt  = 1'b1;
          out_req_nxt.pixel_x     = sx;
          out_req_nxt.pixel_y     = sy;
          out_req_nxt.pixel_color = in_req.line_color;
          out_req_nxt.last        = !active_nxt;
        end
        ACT_STEP: begin
          if (active_r) begin
            err_nxt    = err_r + (minor_step ? diag_r : straight_r);
            cur_x_nxt  = major_x_r ? maj_inc : mnr_mov;
            cur_y_nxt  = major_x_r ? mnr_mov : maj_inc;
            active_nxt = (maj_inc != major_end_r);
            out_valid_nxt = 1'b1;
            out_req_nxt.pixel_x     = cur_x_nxt;
            out_req_nxt.pixel_y     = cur_y_nxt;
            out_req_nxt.pixel_color = color_r;
            out_req_nxt.last        = !active_nxt;
          end
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    major_x_r    <= major_x_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    major_end_r  <= major_end_nxt;
    minor_down_r <= minor_down_nxt;
    err_r        <= err_nxt;
    diag_r       <= diag_nxt;
    straight_r   <= straight_nxt;
    color_r      <= color_nxt;
    out_req_r    <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // checks
  `BLPG_ASSERT_NEXT(a_start_emits, in_accept && in_req.action == ACT_START, out_valid_r, "start request gave no pixel")
  `BLPG_ASSERT_NEXT(a_idle_step_silent, in_accept && in_req.action == ACT_STEP && !active_r, !out_valid_r, "step while idle gave a pixel")
  `BLPG_ASSERT_NOW(a_last_goes_idle, out_valid_r && out_req_r.last, !active_r, "line still active after last pixel")
  `BLPG_ASSERT_NOW(a_active_not_at_end, active_r, (major_x_r ? cur_x_r : cur_y_r) != major_end_r, "active line already at its end")

endmodule

// ===== tb/sv/bresenham_line_pixel_generator_top_tb.sv =====
// Self-checking testbench for the Bresenham line pixel generator.
module bresenham_line_pixel_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blpg_pkg::*;

  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int COLOR_MAX     = (1 << COLOR_BITS) - 1;
  localparam int RUN_TO_END    = 1 << 20;
  localparam int HOLD_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int BURST_ITEMS   = 120;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  bresenham_line_pixel_generator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always #5 clk = ~clk;

  // Line state tracked alongside the block
  logic                       line_busy = 1'b0;
  logic                       x_major = 1'b0;
  logic [COORD_BITS-1:0]      cur_x = '0;
  logic [COORD_BITS-1:0]      cur_y = '0;
  logic [COORD_BITS-1:0]      major_stop = '0;
  logic                       minor_neg = 1'b0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic signed [ERR_BITS-1:0] diag_step = '0;
  logic signed [ERR_BITS-1:0] flat_step = '0;
  logic [COLOR_BITS-1:0]      color_reg = '0;

  out_req_t pixel_q[$];
  out_req_t want_px;

  int  errors = 0;
  int  items_done = 0;
  int  lines_started = 0;
  int  lines_abandoned = 0;
  int  steps_taken = 0;
  int  idle_steps = 0;
  int  pixels_checked = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;

  wire in_take  = rst_n && in_valid && !in_stall;
  wire out_take = rst_n && out_valid && !out_stall;

  // Advance the tracked line by one request; queue the pixel it produces
  task automatic trace_request(input in_req_t r);
    int xa, ya, xb, yb, tmp, dx, dy, dmaj, dmin;
    logic [COORD_BITS-1:0] maj, mnr;
    logic minor_move, at_end;
    out_req_t px;
    if (r.action == ACT_START) begin
      xa = r.x_start;
      ya = r.y_start;
      xb = r.x_end;
      yb = r.y_end;
      dx = (xb >= xa) ? xb - xa : xa - xb;
      dy = (yb >= ya) ? yb - ya : ya - yb;
      color_reg = r.line_color;
      x_major = (dx >= dy);
      // major axis must count upward
      if (x_major ? (xa > xb) : (ya > yb)) begin
        tmp = xa; xa = xb; xb = tmp;
        tmp = ya; ya = yb; yb = tmp;
      end
      if (x_major) begin
        dmaj = dx; dmin = dy;
        major_stop = COORD_BITS'(xb);
        minor_neg = !(yb > ya);
      end else begin
        dmaj = dy; dmin = dx;
        major_stop = COORD_BITS'(yb);
        minor_neg = !(xb > xa);
      end
      err_acc = ERR_BITS'(2 * dmin - dmaj);
      diag_step = ERR_BITS'(2 * (dmin - dmaj));
      flat_step = ERR_BITS'(2 * dmin);
      cur_x = COORD_BITS'(xa);
      cur_y = COORD_BITS'(ya);
      at_end = ((x_major ? cur_x : cur_y) == major_stop);
      line_busy = !at_end;
    end else if (line_busy) begin
      minor_move = (err_acc >= 0);
      err_acc = err_acc + (minor_move ? diag_step : flat_step);
      maj = x_major ? cur_x : cur_y;
      mnr = x_major ? cur_y : cur_x;
      maj = maj + 1'b1;
      if (minor_move) mnr = minor_neg ? mnr - 1'b1 : mnr + 1'b1;
      if (x_major) begin
        cur_x = maj; cur_y = mnr;
      end else begin
        cur_y = maj; cur_x = mnr;
      end
      at_end = (maj == major_stop);
      if (at_end) line_busy = 1'b0;
    end else begin
      return;  // step on an idle block: nothing comes out
    end
    px.pixel_x = cur_x;
    px.pixel_y = cur_y;
    px.pixel_color = color_reg;
    px.last = at_end;
    pixel_q.push_back(px);
  endtask

  function automatic in_req_t make_start(input int xa, ya, xb, yb, color);
    in_req_t r;
    r.action = ACT_START;
    r.x_start = COORD_BITS'(xa);
    r.y_start = COORD_BITS'(ya);
    r.x_end = COORD_BITS'(xb);
    r.y_end = COORD_BITS'(yb);
    r.line_color = COLOR_BITS'(color);
    return r;
  endfunction

  // Step or start request with every field random
  function automatic in_req_t random_req(input bit is_step);
    in_req_t r;
    r = make_start($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COLOR_MAX));
    if (is_step) r.action = ACT_STEP;
    return r;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Offer one request, wait until it is taken, then predict its pixel
  task automatic send_request(input in_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    if (r.action == ACT_START) begin
      lines_started++;
      if (line_busy) lines_abandoned++;
      items_done++;
    end else if (line_busy) begin
      steps_taken++;
      items_done++;
    end else begin
      idle_steps++;
    end
    trace_request(r);
  endtask

  // Start a line, then step it until it ends or max_steps run out
  task automatic run_line(input int xa, ya, xb, yb, color, max_steps);
    int n;
    n = 0;
    send_request(make_start(xa, ya, xb, yb, color));
    while (line_busy && n < max_steps) begin
      send_request(random_req(1'b1));
      n++;
    end
  endtask

  task automatic random_line();
    int xa, ya, xb, yb, span;
    span = ($urandom_range(0, 19) == 0) ? COORD_MAX : 15;
    xa = $urandom_range(0, COORD_MAX);
    ya = $urandom_range(0, COORD_MAX);
    if (span == COORD_MAX) begin
      xb = $urandom_range(0, COORD_MAX);
      yb = $urandom_range(0, COORD_MAX);
    end else begin
      xb = clamp_coord(xa + $urandom_range(0, 2 * span) - span);
      yb = clamp_coord(ya + $urandom_range(0, 2 * span) - span);
    end
    run_line(xa, ya, xb, yb, $urandom_range(0, COLOR_MAX),
             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : RUN_TO_END);
  endtask

  task automatic wait_drain();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Steps on a freshly reset block produce nothing
  task automatic test_idle_steps();
    send_request(random_req(1'b1));
    send_request(random_req(1'b1));
  endtask

  // Lines of one pixel at both corners and both color extremes
  task automatic test_single_pixel();
    run_line(0, 0, 0, 0, 0, RUN_TO_END);
    run_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COLOR_MAX, RUN_TO_END);
  endtask

  // Full-screen diagonals, each cut short by the next start
  task automatic test_corner_lines();
    run_line(0, 0, COORD_MAX, COORD_MAX, 12'h5A5, 2);
    run_line(COORD_MAX, 0, 0, COORD_MAX, 12'hA5A, 1);
    run_line(COORD_MAX, COORD_MAX, 0, 0, COLOR_MAX, 1);
    run_line(0, COORD_MAX, COORD_MAX, 0, 0, 0);
  endtask

  // Steep lines both ways, flat, vertical, equal deltas going down
  task automatic test_line_shapes();
    run_line(4, 0, 5, 3, 12'h0F0, RUN_TO_END);
    run_line(5, 3, 4, 0, 12'hF00, RUN_TO_END);
    run_line(0, 7, 3, 7, 12'h00F, RUN_TO_END);
    run_line(9, 3, 9, 1, 12'h123, RUN_TO_END);
    run_line(5, 1, 2, 4, 12'hFED, RUN_TO_END);
    send_request(random_req(1'b1));
  endtask

  // Receiver holds off while a line keeps coming, so the input backs up
  task automatic test_output_hold();
    hold_request <= 1'b1;
    run_line(0, 0, 20, 7, 12'h3C3, RUN_TO_END);
    hold_request <= 1'b0;
  endtask

  // Mostly whole lines with random endpoints, some noise in between
  task automatic test_random_lines(input int target);
    int goal;
    goal = items_done + target;
    while (items_done < goal) begin
      if ($urandom_range(0, 6) == 0)
        send_request(random_req($urandom_range(0, 1)));
      else
        random_line();
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random_lines(BURST_ITEMS);
  endtask

  // Output stall: random bursts, plus one long hold while hold_request is set
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_request);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each taken pixel with the oldest prediction
  always @(posedge clk) begin
    if (out_take) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel with none expected, expected nothing, got %p", $time, out_req);
        errors++;
      end else begin
        want_px = pixel_q.pop_front();
        check_field("pixel_x", int'(want_px.pixel_x), int'(out_req.pixel_x));
        check_field("pixel_y", int'(want_px.pixel_y), int'(out_req.pixel_y));
        check_field("pixel_color", int'(want_px.pixel_color),
                    int'(out_req.pixel_color));
        check_field("last", int'(want_px.last), int'(out_req.last));
        pixels_checked++;
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (in_take || out_take) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d pixels outstanding",
               $time, QUIET_LIMIT, pixel_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_steps();
    test_single_pixel();
    test_corner_lines();
    test_line_shapes();
    test_output_hold();
    test_random_lines(RANDOM_ITEMS);
    test_full_rate();
    in_valid <= 1'b0;
    wait_drain();
    $display("Covered %0d lines (%0d cut short by a new start), %0d steps, %0d idle steps,",
             lines_started, lines_abandoned, steps_taken, idle_steps);
    $display("%0d pixels checked, one %0d-cycle output hold, random stalls on both sides.",
             pixels_checked, HOLD_CYCLES);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
